/* src/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
// Depends on nothing; imported by spq_cell and sorted_priority_queue.
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;
  localparam logic [1:0] OP_PEEK   = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic               upd;    // shift this cycle
    logic               ins;    // 1 insert, 0 remove
    logic signed [31:0] value;  // key of the current request
  } cell_ctl_t;

endpackage

/* src/spq_cell.sv */
// One slot of the sorted chain: holds a value, compares it to the request key
// and shifts left or right with its neighbors. Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic               in_use,
  input  logic               left_ge,
  input  logic signed [31:0] left_val,
  input  logic signed [31:0] right_val,
  output logic signed [31:0] val,
  output logic               ge,
  output logic               eq
);

  logic signed [31:0] val_r;
  logic signed [31:0] val_nxt;

  // Unused slots act as "greater or equal" so the ge row stays a thermometer
  assign ge  = !in_use || (val_r >= ctl.value);
  assign eq  = in_use && (val_r == ctl.value);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.upd) begin
      if (ctl.ins) begin
        if (ge && !left_ge) begin
          val_nxt = ctl.value;
        end else if (ge && left_ge) begin
          val_nxt = left_val;
        end
      end else if (ge) begin
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

/* src/sorted_priority_queue.sv */
// Top level of the sorted priority queue: request register, chain of cells,
// result register. Depends on spq_pkg and spq_cell.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------
//   in_     | input     | in_valid / in_stall | func, item_value
//   out_    | output    | out_valid/out_stall | status, position, head_valid,
//           |           |                     | smallest_value, occupancy
//
// Each request is handled in turn: the beat is captured in the request register,
// then in the next cycle every cell compares in parallel, the chain shifts by
// one slot and the result register loads. One request is in flight at a time.
// in_stall is high while a request is in flight or the previous result beat is
// still held by out_stall; a held result keeps the request waiting.
// Reset (rst_n low, synchronous) empties the queue and drops any pending beat.
// The cell contents are not cleared; slots at or above the count are marked unused.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_item_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [3:0]         out_position,
  output logic               out_head_valid,
  output logic signed [31:0] out_smallest_value,
  output logic [4:0]         out_occupancy
);

  // Request register
  logic               job_vld_r, job_vld_nxt;
  logic [1:0]         job_func_r;
  logic signed [31:0] job_val_r;

  // Queue occupancy
  logic [CNT_W-1:0]   count_r, count_nxt;

  // Result register
  logic               out_vld_r, out_vld_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [3:0]         pos_r, pos_nxt;
  logic               headv_r;
  logic signed [31:0] small_r, small_nxt;
  logic [4:0]         occ_r;

  logic in_take;
  logic job_done;

  cell_ctl_t          ctl;
  logic signed [31:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0] ge_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] first_oh;
  logic [3:0]          first_pos;
  logic                hit;
  logic                full;
  logic                ins_ok;
  logic                rem_ok;
  logic signed [31:0]  head_nxt;

  // Handshakes: hold the request until the result register can take it
  assign in_stall = job_vld_r || (out_vld_r && out_stall);
  assign in_take  = in_valid && !in_stall;
  assign job_done = job_vld_r && (!out_vld_r || !out_stall);

  // Locate the insertion / match slot: the ge row is a thermometer
  assign first_oh = ge_vec & ~{ge_vec[CAPACITY-2:0], 1'b0};
  assign hit      = |(eq_vec & first_oh);
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign ins_ok   = (job_func_r == OP_INSERT) && !full;
  assign rem_ok   = (job_func_r == OP_REMOVE) && hit;

  always_comb begin
    first_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_oh[i]) begin
        first_pos = first_pos | 4'(i);
      end
    end
  end

  // Broadcast: advance the chain only on the beat that completes, for an insert with room or a remove that hit
  assign ctl.upd   = job_done && (ins_ok || rem_ok);
  assign ctl.ins   = (job_func_r == OP_INSERT);
  assign ctl.value = job_val_r;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic               l_ge;
    logic signed [31:0] l_val;
    logic signed [31:0] r_val;

    if (g == 0) begin : g_first
      assign l_ge  = 1'b0;
      assign l_val = '0;
    end else begin : g_mid
      assign l_ge  = ge_vec[g-1];
      assign l_val = cell_val[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign r_val = cell_val[g];
    end else begin : g_inner
      assign r_val = cell_val[g+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .in_use    (CNT_W'(g) < count_r),
      .left_ge   (l_ge),
      .left_val  (l_val),
      .right_val (r_val),
      .val       (cell_val[g]),
      .ge        (ge_vec[g]),
      .eq        (eq_vec[g])
    );
  end

  // Count and head after this request
  always_comb begin
    count_nxt = count_r;
    if (ctl.upd && ins_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.upd && rem_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    head_nxt = cell_val[0];
    if (ins_ok && ge_vec[0]) begin
      head_nxt = job_val_r;
    end else if (rem_ok && ge_vec[0]) begin
      head_nxt = cell_val[1];
    end
  end

  // Status and position per operation
  always_comb begin
    status_nxt = ST_DONE;
    pos_nxt    = '0;
    case (job_func_r)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          pos_nxt = first_pos;
        end
      end
      OP_REMOVE, OP_FIND: begin
        if (hit) begin
          pos_nxt = first_pos;
        end else begin
          status_nxt = ST_MISS;
        end
      end
      OP_PEEK: begin
        if (count_r == '0) begin
          status_nxt = ST_MISS;
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  assign small_nxt   = (count_nxt != '0) ? head_nxt : '0;
  assign job_vld_nxt = in_take ? 1'b1 : (job_done ? 1'b0 : job_vld_r);
  assign out_vld_nxt = job_done ? 1'b1 : (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      count_r   <= '0;
    end else begin
      job_vld_r <= job_vld_nxt;
      out_vld_r <= out_vld_nxt;
      count_r   <= count_nxt;
    end
  end

  // Payload registers: capture the request beat, load the result beat
  always_ff @(posedge clk) begin
    if (in_take) begin
      job_func_r <= in_func;
      job_val_r  <= in_item_value;
    end
    if (job_done) begin
      status_r <= status_nxt;
      pos_r    <= pos_nxt;
      headv_r  <= (count_nxt != '0);
      small_r  <= small_nxt;
      occ_r    <= 5'(count_nxt);
    end
  end

  assign out_valid          = out_vld_r;
  assign out_status         = status_r;
  assign out_position       = pos_r;
  assign out_head_valid     = headv_r;
  assign out_smallest_value = small_r;
  assign out_occupancy      = occ_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_slot_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    job_vld_r |-> $onehot0(first_oh))
    else $error("slot select not one-hot");

  a_take_starts_job: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> job_vld_r && in_stall)
    else $error("accepted beat did not start a request");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && status_r == ST_FULL) |-> (occ_r == 5'(CAPACITY)))
    else $error("full status with free slots");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !job_done |=> $stable(count_r))
    else $error("occupancy changed outside a request");

endmodule
